>>> sv/mfs_pkg.sv
package mfs_pkg;

    localparam int CAPACITY_DEFAULT = 64;
    localparam int VALUE_W = 32;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL = 2'd2;

    localparam logic ACTION_PUSH = 1'b0;
    localparam logic ACTION_POP  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH_SCAN,
        ST_POP_FIND,
        ST_POP_SHIFT,
        ST_POP_LEVEL,
        ST_DONE
    } state_t;

endpackage

>>> sv/max_frequency_stack_core.sv
// Max-frequency stack: a store of up to CAPACITY 32-bit words, each tagged at push time
// with its level (one more than the stored copies of the same word). A pop removes the
// newest entry at the highest level. Raise start for one cycle with action and value while
// busy is low; busy stays high until the one result beat, marked by done, which shows
// status and popped for exactly one cycle and cannot be stalled. Entries live in two
// synchronous memories (value and level), each with one read port and one write port and
// a registered read, and every successful operation walks them one address per cycle. A
// push is a count scan over the stored entries plus a write. A pop is a downward search
// that can walk the whole store, a compaction pass moving one entry per cycle, and a scan
// for anything left at the top level. Errors (pop on empty, push on full) put the result
// beat in the cycle right after the accepting edge. No clearing pass is needed after
// reset: only addresses below the occupancy count are ever read.
module max_frequency_stack_core #(
    parameter int CAPACITY = mfs_pkg::CAPACITY_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          action,
    input  logic [mfs_pkg::VALUE_W-1:0]   value,
    output logic                          done,
    output logic [mfs_pkg::STATUS_W-1:0]  status,
    output logic [mfs_pkg::VALUE_W-1:0]   popped
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = CW;

    mfs_pkg::state_t state_reg, state_next;

    logic [mfs_pkg::VALUE_W-1:0] val_mem [CAPACITY];
    logic [LW-1:0]               lvl_mem [CAPACITY];

    logic [CW-1:0] occ_reg, occ_next;
    logic [LW-1:0] top_reg, top_next;
    logic [CW-1:0] idx_reg, idx_next;    // address being read this cycle
    logic [LW-1:0] cnt_reg, cnt_next;    // copy count for push
    logic [mfs_pkg::VALUE_W-1:0] word_reg, word_next;
    logic          rv_reg, rv_next;      // read data valid next cycle
    logic [CW-1:0] ra_reg, ra_next;      // address of registered read data
    logic          left_reg, left_next;
    logic [mfs_pkg::STATUS_W-1:0] st_reg, st_next;

    logic [mfs_pkg::VALUE_W-1:0] rd_val;
    logic [LW-1:0]               rd_lvl;
    logic          we;
    logic [AW-1:0] wa, ra;
    logic [mfs_pkg::VALUE_W-1:0] wd_val;
    logic [LW-1:0]               wd_lvl;
    logic          re;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            val_mem[wa] <= wd_val;
            lvl_mem[wa] <= wd_lvl;
        end
        if (re)
        begin
            rd_val <= val_mem[ra];
            rd_lvl <= lvl_mem[ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mfs_pkg::ST_IDLE;
            occ_reg   <= '0;
            top_reg   <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            top_reg   <= top_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        cnt_reg  <= cnt_next;
        word_reg <= word_next;
        ra_reg   <= ra_next;
        left_reg <= left_next;
        st_reg   <= st_next;
    end

    // Next-state and datapath sequencing
    always_comb
    begin
        state_next = state_reg;
        occ_next   = occ_reg;
        top_next   = top_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        word_next  = word_reg;
        rv_next    = 1'b0;
        ra_next    = idx_reg;
        left_next  = left_reg;
        st_next    = st_reg;
        we = 1'b0; wa = '0; wd_val = '0; wd_lvl = '0;
        re = 1'b0; ra = idx_reg[AW-1:0];
        unique case (state_reg)
            mfs_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    st_next   = mfs_pkg::STATUS_OK;
                    word_next = '0;
                    cnt_next  = '0;
                    left_next = 1'b0;
                    if (action == mfs_pkg::ACTION_PUSH)
                    begin
                        if (occ_reg == CW'(CAPACITY))
                        begin
                            st_next = mfs_pkg::STATUS_PUSH_FULL;
                            state_next = mfs_pkg::ST_DONE;
                        end
                        else
                        begin
                            word_next  = value;
                            idx_next   = '0;
                            state_next = mfs_pkg::ST_PUSH_SCAN;
                        end
                    end
                    else if (occ_reg == '0)
                    begin
                        st_next = mfs_pkg::STATUS_POP_EMPTY;
                        state_next = mfs_pkg::ST_DONE;
                    end
                    else
                    begin
                        idx_next   = occ_reg - 1'b1;
                        state_next = mfs_pkg::ST_POP_FIND;
                    end
                end
            end
            mfs_pkg::ST_PUSH_SCAN:
            begin
                // count matches on the beat read last cycle
                if (rv_reg && rd_val == word_reg)
                    cnt_next = cnt_reg + 1'b1;
                if (idx_reg < occ_reg)
                begin
                    re = 1'b1;
                    rv_next = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                else if (!rv_reg)
                begin
                    we = 1'b1;
                    wa = occ_reg[AW-1:0];
                    wd_val = word_reg;
                    wd_lvl = cnt_reg + 1'b1;
                    occ_next = occ_reg + 1'b1;
                    if (cnt_reg + 1'b1 > top_reg)
                        top_next = cnt_reg + 1'b1;
                    word_next = '0;
                    state_next = mfs_pkg::ST_DONE;
                end
            end
            mfs_pkg::ST_POP_FIND:
            begin
                // search downward for the newest entry at the top level
                if (rv_reg && (rd_lvl == top_reg || ra_reg == '0))
                begin
                    word_next = rd_val;
                    idx_next  = ra_reg + 1'b1;
                    state_next = mfs_pkg::ST_POP_SHIFT;
                end
                else if (!rv_reg || ra_reg != '0)
                begin
                    re = 1'b1;
                    rv_next = 1'b1;
                    ra_next = idx_reg;
                    idx_next = idx_reg - 1'b1;
                end
            end
            mfs_pkg::ST_POP_SHIFT:
            begin
                // move each entry above the hole down by one
                if (rv_reg)
                begin
                    we = 1'b1;
                    wa = AW'(ra_reg - 1'b1);
                    wd_val = rd_val;
                    wd_lvl = rd_lvl;
                end
                if (idx_reg < occ_reg)
                begin
                    re = 1'b1;
                    rv_next = 1'b1;
                    ra_next = idx_reg;
                    idx_next = idx_reg + 1'b1;
                end
                else if (!rv_reg)
                begin
                    occ_next = occ_reg - 1'b1;
                    idx_next = '0;
                    state_next = mfs_pkg::ST_POP_LEVEL;
                end
            end
            mfs_pkg::ST_POP_LEVEL:
            begin
                if (rv_reg && rd_lvl == top_reg)
                    left_next = 1'b1;
                if (idx_reg < occ_reg)
                begin
                    re = 1'b1;
                    rv_next = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                else if (!rv_reg)
                begin
                    if (occ_reg == '0)
                        top_next = '0;
                    else if (!left_next && top_reg != '0)
                        top_next = top_reg - 1'b1;
                    state_next = mfs_pkg::ST_DONE;
                end
            end
            mfs_pkg::ST_DONE:
                state_next = mfs_pkg::ST_IDLE;
            default:
                state_next = mfs_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        busy   = (state_reg != mfs_pkg::ST_IDLE);
        done   = (state_reg == mfs_pkg::ST_DONE);
        status = st_reg;
        popped = word_reg;
    end

    // Occupancy never exceeds capacity
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CW'(CAPACITY))
        else $error("occupancy above capacity");

    // A successful pop lowers occupancy before the level scan, so it holds at the result
    a_pop_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == mfs_pkg::STATUS_OK && $past(state_reg) == mfs_pkg::ST_POP_LEVEL)
        |-> occ_reg == $past(occ_reg))
        else $error("pop occupancy mismatch");

    // An empty store has level zero
    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mfs_pkg::ST_IDLE && occ_reg == '0) |-> top_reg == '0)
        else $error("top level set on empty store");

    // A result beat is always followed by an idle cycle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("done not followed by idle");

endmodule
